// ===== src/cau_pkg.sv =====
`timescale 1ns / 1ps
package cau_pkg;

   localparam int CMD_BITS = 4;
   localparam int OUT_BITS = 32;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD   = 4'd0,
      CMD_SUB   = 4'd1,
      CMD_MUL   = 4'd2,
      CMD_DIV   = 4'd3,
      CMD_SMUL  = 4'd4,
      CMD_SDIV  = 4'd5,
      CMD_CONJ  = 4'd6,
      CMD_MOD   = 4'd7,
      CMD_EQUAL = 4'd8
   } cmd_type;

   // per-word control carried from the front to the back
   typedef struct packed {
      logic div_en;    // divide by dvs, else divisor is one
      logic sq_en;     // real part comes from the square root lane
      logic is_equal;
      logic div_zero;
   } flags_type;

endpackage

// ===== src/cau_req_if.sv =====
`timescale 1ns / 1ps
interface cau_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [cau_pkg::CMD_BITS-1:0]   command;
   logic signed [cau_pkg::OUT_BITS-1:0]   a_re;
   logic signed [cau_pkg::OUT_BITS-1:0]   a_im;
   logic signed [cau_pkg::OUT_BITS-1:0]   b_re;
   logic signed [cau_pkg::OUT_BITS-1:0]   b_im;

   modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
   modport sink (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

// ===== src/cau_rsp_if.sv =====
`timescale 1ns / 1ps
interface cau_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cau_pkg::OUT_BITS-1:0]   res_re;
   logic signed [cau_pkg::OUT_BITS-1:0]   res_im;
   logic                                  is_equal;
   logic                                  div_zero;
   logic                                  overflow;

   modport source (output valid, res_re, res_im, is_equal, div_zero, overflow, input ready);
   modport sink (input valid, res_re, res_im, is_equal, div_zero, overflow, output ready);
endinterface

// ===== src/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Contents
// req_ch    in         command, a_re, a_im, b_re, b_im
// rsp_ch    out        res_re, res_im, is_equal, div_zero, overflow
//
// One word per cycle while rsp_ch takes results. A word passes two front stages
// (multipliers, then sums and sign), one queue slot, a prep stage, WORD_BITS digit
// stages (restoring division on both parts, square root beside it), and the output
// register. Reset is synchronous and clears only valid bits and the queue pointers
// and count. A waiting result freezes the back pipeline; the front keeps taking words
// until the queue credit (queue words plus front stages) reaches QUEUE_DEPTH.
module complex_arithmetic_unit #(
   parameter int WORD_BITS   = 32,
   parameter int FRAC_BITS   = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input logic         clock,
   input logic         reset,
   cau_req_if.sink     req_ch,
   cau_rsp_if.source   rsp_ch
);
   localparam int W  = WORD_BITS;
   localparam int DW = 2 * W;
   localparam int MW = 2 * W + 1;
   localparam int FB = $bits(cau_pkg::flags_type);
   localparam int QW = FB + 2 + 2 * MW + 2 * DW;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // front: decode, products, sign and magnitude
   logic               f_valid;
   logic [1:0]         f_inflight;
   logic               f_re_neg, f_im_neg;
   logic [MW-1:0]      f_re_mag, f_im_mag;
   logic [DW-1:0]      f_dvs, f_sq_n;
   cau_pkg::flags_type f_flags;

   logic               req_take;
   logic [CW-1:0]      q_count;
   logic [CW:0]        credit;

   // a word is only taken when a queue slot is already reserved for it
   assign credit       = (CW + 1)'(q_count) + (CW + 1)'(f_inflight);
   assign req_ch.ready = credit < (CW + 1)'(QUEUE_DEPTH);
   assign req_take     = req_ch.valid && req_ch.ready;

   cau_front #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .command   (req_ch.command),
      .a_re      (req_ch.a_re),
      .a_im      (req_ch.a_im),
      .b_re      (req_ch.b_re),
      .b_im      (req_ch.b_im),
      .out_valid (f_valid),
      .inflight  (f_inflight),
      .re_neg    (f_re_neg),
      .re_mag    (f_re_mag),
      .im_neg    (f_im_neg),
      .im_mag    (f_im_mag),
      .dvs       (f_dvs),
      .sq_n      (f_sq_n),
      .flags     (f_flags)
   );

   // queue between front and back
   logic [QW-1:0]      q_wdata, q_rdata;
   logic               q_empty, q_pop, b_ready;
   logic               q_re_neg, q_im_neg;
   logic [MW-1:0]      q_re_mag, q_im_mag;
   logic [DW-1:0]      q_dvs, q_sq_n;
   cau_pkg::flags_type q_flags;

   assign q_wdata = {f_flags, f_re_neg, f_re_mag, f_im_neg, f_im_mag, f_dvs, f_sq_n};
   assign {q_flags, q_re_neg, q_re_mag, q_im_neg, q_im_mag, q_dvs, q_sq_n} = q_rdata;
   assign q_pop   = b_ready && !q_empty;

   cau_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .count     (q_count),
      .empty     (q_empty)
   );

   // back: digit pipeline and saturation
   cau_back #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_ready  (b_ready),
      .re_neg    (q_re_neg),
      .re_mag    (q_re_mag),
      .im_neg    (q_im_neg),
      .im_mag    (q_im_mag),
      .dvs       (q_dvs),
      .sq_n      (q_sq_n),
      .flags     (q_flags),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .res_re    (rsp_ch.res_re),
      .res_im    (rsp_ch.res_im),
      .is_equal  (rsp_ch.is_equal),
      .div_zero  (rsp_ch.div_zero),
      .overflow  (rsp_ch.overflow)
   );

`ifndef SYNTHESIS
   // credit scheme must never push into a full queue
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      f_valid |-> (q_count < CW'(QUEUE_DEPTH)))
      else $error("queue push while full");

   // zero divisor gives an all-zero result without overflow
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.div_zero) |->
         (rsp_ch.res_re == '0 && rsp_ch.res_im == '0 && !rsp_ch.overflow))
      else $error("div_zero word with nonzero payload");

   // equality and zero divisor come from different commands
   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.is_equal && rsp_ch.div_zero))
      else $error("is_equal and div_zero both set");
`endif
endmodule

// ===== src/cau_front.sv =====
`timescale 1ns / 1ps
module cau_front #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [cau_pkg::CMD_BITS-1:0]       command,
   input  logic signed [cau_pkg::OUT_BITS-1:0] a_re,
   input  logic signed [cau_pkg::OUT_BITS-1:0] a_im,
   input  logic signed [cau_pkg::OUT_BITS-1:0] b_re,
   input  logic signed [cau_pkg::OUT_BITS-1:0] b_im,
   output logic                               out_valid,
   output logic [1:0]                         inflight,
   output logic                               re_neg,
   output logic [2*WORD_BITS:0]               re_mag,
   output logic                               im_neg,
   output logic [2*WORD_BITS:0]               im_mag,
   output logic [2*WORD_BITS-1:0]             dvs,
   output logic [2*WORD_BITS-1:0]             sq_n,
   output cau_pkg::flags_type                 flags
);
   localparam int W  = WORD_BITS;
   localparam int DW = 2 * W;
   localparam int MW = 2 * W + 1;

   logic signed [W-1:0] ar, ai, br, bi, sx, sy;
   logic                sq_sel;

   assign ar = $signed(W'($unsigned(a_re)));
   assign ai = $signed(W'($unsigned(a_im)));
   assign br = $signed(W'($unsigned(b_re)));
   assign bi = $signed(W'($unsigned(b_im)));
   assign sq_sel = (cau_pkg::cmd_type'(command) == cau_pkg::CMD_MOD);
   assign sx = sq_sel ? ar : br;
   assign sy = sq_sel ? ai : bi;

   // stage 1: products
   logic                   v1_ff;
   cau_pkg::cmd_type       cmd1_ff;
   logic signed [W-1:0]    ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [DW-1:0]   p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [DW-1:0]   p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;

   assign p0_in = DW'(ar) * DW'(br);
   assign p1_in = DW'(ai) * DW'(bi);
   assign p2_in = DW'(ar) * DW'(bi);
   assign p3_in = DW'(ai) * DW'(br);
   assign p4_in = DW'(sx) * DW'(sx);
   assign p5_in = DW'(sy) * DW'(sy);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      cmd1_ff <= cau_pkg::cmd_type'(command);
      ar1_ff  <= ar;
      ai1_ff  <= ai;
      br1_ff  <= br;
      bi1_ff  <= bi;
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      p3_ff   <= p3_in;
      p4_ff   <= p4_in;
      p5_ff   <= p5_in;
   end

   // stage 2: sums, sign and magnitude
   logic signed [MW-1:0] sre, sim;
   logic                 shr, dneg;
   logic [DW-1:0]        d_c, sqn_c;
   logic [W-1:0]         brm;
   cau_pkg::flags_type   fl_c;

   assign brm = br1_ff[W-1] ? W'($unsigned(-br1_ff)) : W'($unsigned(br1_ff));

   always_comb begin
      sre   = '0;
      sim   = '0;
      shr   = 1'b0;
      dneg  = 1'b0;
      d_c   = '0;
      sqn_c = '0;
      fl_c  = '0;
      case (cmd1_ff)
         cau_pkg::CMD_ADD: begin
            sre = MW'(ar1_ff) + MW'(br1_ff);
            sim = MW'(ai1_ff) + MW'(bi1_ff);
         end
         cau_pkg::CMD_SUB: begin
            sre = MW'(ar1_ff) - MW'(br1_ff);
            sim = MW'(ai1_ff) - MW'(bi1_ff);
         end
         cau_pkg::CMD_MUL: begin
            sre = MW'(p0_ff) - MW'(p1_ff);
            sim = MW'(p2_ff) + MW'(p3_ff);
            shr = 1'b1;
         end
         cau_pkg::CMD_DIV: begin
            if (br1_ff == '0 && bi1_ff == '0) begin
               fl_c.div_zero = 1'b1;
            end else begin
               sre = MW'(p0_ff) + MW'(p1_ff);
               sim = MW'(p3_ff) - MW'(p2_ff);
               d_c = $unsigned(p4_ff) + $unsigned(p5_ff);
               fl_c.div_en = 1'b1;
            end
         end
         cau_pkg::CMD_SMUL: begin
            sre = MW'(p0_ff);
            sim = MW'(p3_ff);
            shr = 1'b1;
         end
         cau_pkg::CMD_SDIV: begin
            if (br1_ff == '0) begin
               fl_c.div_zero = 1'b1;
            end else begin
               sre  = MW'(ar1_ff);
               sim  = MW'(ai1_ff);
               dneg = br1_ff[W-1];
               d_c  = DW'(brm);
               fl_c.div_en = 1'b1;
            end
         end
         cau_pkg::CMD_CONJ: begin
            sre = MW'(ar1_ff);
            sim = -MW'(ai1_ff);
         end
         cau_pkg::CMD_MOD: begin
            sqn_c = $unsigned(p4_ff) + $unsigned(p5_ff);
            fl_c.sq_en = 1'b1;
         end
         cau_pkg::CMD_EQUAL: begin
            fl_c.is_equal = (ar1_ff == br1_ff) && (ai1_ff == bi1_ff);
         end
         default: begin
         end
      endcase
   end

   logic [MW-1:0] rmag_c, imag_c;
   assign rmag_c = sre[MW-1] ? $unsigned(-sre) : $unsigned(sre);
   assign imag_c = sim[MW-1] ? $unsigned(-sim) : $unsigned(sim);

   logic               v2_ff;
   logic               re_neg_ff, im_neg_ff;
   logic [MW-1:0]      re_mag_ff, im_mag_ff;
   logic [DW-1:0]      dvs_ff, sq_n_ff;
   cau_pkg::flags_type flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      re_neg_ff <= sre[MW-1] ^ dneg;
      im_neg_ff <= sim[MW-1] ^ dneg;
      re_mag_ff <= shr ? (rmag_c >> FRAC_BITS) : rmag_c;
      im_mag_ff <= shr ? (imag_c >> FRAC_BITS) : imag_c;
      dvs_ff    <= d_c;
      sq_n_ff   <= sqn_c;
      flags_ff  <= fl_c;
   end

   assign out_valid = v2_ff;
   assign inflight  = {1'b0, v1_ff} + {1'b0, v2_ff};
   assign re_neg    = re_neg_ff;
   assign im_neg    = im_neg_ff;
   assign re_mag    = re_mag_ff;
   assign im_mag    = im_mag_ff;
   assign dvs       = dvs_ff;
   assign sq_n      = sq_n_ff;
   assign flags     = flags_ff;
endmodule

// ===== src/cau_queue.sv =====
`timescale 1ns / 1ps
module cau_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic [$clog2(DEPTH+1)-1:0]   count,
   output logic                         empty
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PW-1:0]    wr_ff, rd_ff, wr_in, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign wr_in  = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign rd_in  = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
   assign cnt_in = cnt_ff + CW'(push) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_in;
         if (pop) rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assign pop_data = mem_ff[rd_ff];
   assign count    = cnt_ff;
   assign empty    = (cnt_ff == '0);
endmodule

// ===== src/cau_back.sv =====
`timescale 1ns / 1ps
module cau_back #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic                                re_neg,
   input  logic [2*WORD_BITS:0]                re_mag,
   input  logic                                im_neg,
   input  logic [2*WORD_BITS:0]                im_mag,
   input  logic [2*WORD_BITS-1:0]              dvs,
   input  logic [2*WORD_BITS-1:0]              sq_n,
   input  cau_pkg::flags_type                  flags,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [cau_pkg::OUT_BITS-1:0] res_re,
   output logic signed [cau_pkg::OUT_BITS-1:0] res_im,
   output logic                                is_equal,
   output logic                                div_zero,
   output logic                                overflow
);
   localparam int W  = WORD_BITS;
   localparam int DW = 2 * W;
   localparam int MW = 2 * W + 1;
   localparam int NW = MW + FRAC_BITS;
   localparam int OB = cau_pkg::OUT_BITS;

   function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic b,
                                            input logic [DW-1:0] d);
      logic [DW:0] t;
      logic [DW:0] diff;
      t    = {rem, b};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) return {1'b1, diff[DW-1:0]};
      else return {1'b0, t[DW-1:0]};
   endfunction

   function automatic logic [W+2:0] sq_step(input logic [W+1:0] rem, input logic [1:0] b,
                                            input logic [W-1:0] root);
      logic [W+3:0] t;
      logic [W+3:0] trial;
      logic [W+3:0] diff;
      t     = {rem, b};
      trial = {2'b00, root, 2'b01};
      diff  = t - trial;
      if (t >= trial) return {1'b1, diff[W+1:0]};
      else return {1'b0, t[W+1:0]};
   endfunction

   // {overflow, saturated value}
   function automatic logic [OB:0] sat(input logic neg, input logic big, input logic [W-1:0] q);
      logic [W-1:0]    lim;
      logic [W-1:0]    m;
      logic            ovf;
      logic signed [W:0] v;
      lim = neg ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
      ovf = big || (q > lim);
      m   = ovf ? lim : q;
      v   = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
      return {ovf, OB'(v)};
   endfunction

   logic en;

   // stage 0: numerator, divisor and range check
   logic [NW-1:0] n_re, n_im, nh_re, nh_im;
   logic [DW-1:0] d0;

   assign d0    = flags.div_en ? dvs : DW'(1);
   assign n_re  = flags.div_en ? (NW'(re_mag) << FRAC_BITS) : NW'(re_mag);
   assign n_im  = flags.div_en ? (NW'(im_mag) << FRAC_BITS) : NW'(im_mag);
   assign nh_re = n_re >> W;
   assign nh_im = n_im >> W;

   logic               v_ff    [0:W];
   cau_pkg::flags_type fl_ff   [0:W];
   logic [DW-1:0]      d_ff    [0:W];
   logic               rneg_ff [0:W];
   logic               rbig_ff [0:W];
   logic [DW-1:0]      rrem_ff [0:W];
   logic [W-1:0]       rlo_ff  [0:W];
   logic [W-1:0]       rq_ff   [0:W];
   logic               ineg_ff [0:W];
   logic               ibig_ff [0:W];
   logic [DW-1:0]      irem_ff [0:W];
   logic [W-1:0]       ilo_ff  [0:W];
   logic [W-1:0]       iq_ff   [0:W];
   logic [W+1:0]       srem_ff [0:W];
   logic [W-1:0]       sroot_ff[0:W];
   logic [DW-1:0]      sn_ff   [0:W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fl_ff[0]    <= flags;
         d_ff[0]     <= d0;
         rneg_ff[0]  <= re_neg;
         rbig_ff[0]  <= nh_re >= NW'(d0);
         rrem_ff[0]  <= DW'(nh_re);
         rlo_ff[0]   <= n_re[W-1:0];
         rq_ff[0]    <= '0;
         ineg_ff[0]  <= im_neg;
         ibig_ff[0]  <= nh_im >= NW'(d0);
         irem_ff[0]  <= DW'(nh_im);
         ilo_ff[0]   <= n_im[W-1:0];
         iq_ff[0]    <= '0;
         srem_ff[0]  <= '0;
         sroot_ff[0] <= '0;
         sn_ff[0]    <= sq_n;
      end
   end

   // one quotient bit per lane and one root bit per stage
   for (genvar k = 1; k <= W; k++) begin : g_step
      logic [DW:0]  rst_in, ist_in;
      logic [W+2:0] sst_in;

      assign rst_in = div_step(rrem_ff[k-1], rlo_ff[k-1][W-1], d_ff[k-1]);
      assign ist_in = div_step(irem_ff[k-1], ilo_ff[k-1][W-1], d_ff[k-1]);
      assign sst_in = sq_step(srem_ff[k-1], sn_ff[k-1][DW-1:DW-2], sroot_ff[k-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            fl_ff[k]    <= fl_ff[k-1];
            d_ff[k]     <= d_ff[k-1];
            rneg_ff[k]  <= rneg_ff[k-1];
            rbig_ff[k]  <= rbig_ff[k-1];
            rrem_ff[k]  <= rst_in[DW-1:0];
            rlo_ff[k]   <= rlo_ff[k-1] << 1;
            rq_ff[k]    <= {rq_ff[k-1][W-2:0], rst_in[DW]};
            ineg_ff[k]  <= ineg_ff[k-1];
            ibig_ff[k]  <= ibig_ff[k-1];
            irem_ff[k]  <= ist_in[DW-1:0];
            ilo_ff[k]   <= ilo_ff[k-1] << 1;
            iq_ff[k]    <= {iq_ff[k-1][W-2:0], ist_in[DW]};
            srem_ff[k]  <= sst_in[W+1:0];
            sroot_ff[k] <= {sroot_ff[k-1][W-2:0], sst_in[W+2]};
            sn_ff[k]    <= sn_ff[k-1] << 2;
         end
      end
   end

   // saturation into the output register
   logic [OB:0] sre_c, sim_c;
   assign sre_c = fl_ff[W].sq_en ? sat(1'b0, 1'b0, sroot_ff[W])
                                 : sat(rneg_ff[W], rbig_ff[W], rq_ff[W]);
   assign sim_c = sat(ineg_ff[W], ibig_ff[W], iq_ff[W]);

   logic              out_v_ff;
   logic [OB-1:0]     res_re_ff, res_im_ff;
   logic              eq_ff, dz_ff, ovf_ff;

   assign en = !out_v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= v_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_re_ff <= sre_c[OB-1:0];
         res_im_ff <= sim_c[OB-1:0];
         eq_ff     <= fl_ff[W].is_equal;
         dz_ff     <= fl_ff[W].div_zero;
         ovf_ff    <= sre_c[OB] || sim_c[OB];
      end
   end

   assign in_ready  = en;
   assign out_valid = out_v_ff;
   assign res_re    = $signed(res_re_ff);
   assign res_im    = $signed(res_im_ff);
   assign is_equal  = eq_ff;
   assign div_zero  = dz_ff;
   assign overflow  = ovf_ff;
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

   localparam int RAND_WORDS  = 1930;
   localparam int QUIET_TAIL  = 150;      // last words run with no idling
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 60;

   localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE   = 32'sh0001_0000;   // 1.0 in Q16.16

   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic               is_equal;
      logic               div_zero;
      logic               overflow;
   } result_type;

   typedef struct packed {
      logic [3:0]         command;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
      logic               typed;       // result typed in below, not predicted
      result_type         res;
   } stim_row_type;

   localparam result_type NO_RES = '{32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0};
   localparam int N_DIR = 20;

   // directed words: extremes, every command, zero divisors, saturation
   stim_row_type dir_tab [N_DIR] = '{
      '{cau_pkg::CMD_ADD, ONE, 32'sd0, 2*ONE, 32'sd0, 1'b1,
        '{3*ONE, 32'sd0, 1'b0, 1'b0, 1'b0}},
      '{cau_pkg::CMD_ADD, S_MAX, S_MIN, 32'sd1, -32'sd1, 1'b1,
        '{S_MAX, S_MIN, 1'b0, 1'b0, 1'b1}},
      '{cau_pkg::CMD_SUB, S_MIN, S_MAX, 32'sd1, -32'sd1, 1'b1,
        '{S_MIN, S_MAX, 1'b0, 1'b0, 1'b1}},
      '{cau_pkg::CMD_SUB, -32'sd5, 32'sd7, 32'sd3, 32'sd9, 1'b0, NO_RES},
      '{cau_pkg::CMD_MUL, ONE, ONE, ONE, -ONE, 1'b0, NO_RES},
      '{cau_pkg::CMD_MUL, S_MAX, S_MAX, S_MAX, S_MAX, 1'b0, NO_RES},
      '{cau_pkg::CMD_MUL, S_MIN, S_MIN, S_MIN, S_MIN, 1'b0, NO_RES},
      '{cau_pkg::CMD_DIV, ONE, ONE, 32'sd0, 32'sd0, 1'b1,
        '{32'sd0, 32'sd0, 1'b0, 1'b1, 1'b0}},
      '{cau_pkg::CMD_DIV, ONE, 32'sd0, 32'sd0, ONE, 1'b0, NO_RES},
      '{cau_pkg::CMD_DIV, S_MAX, S_MIN, 32'sd1, 32'sd0, 1'b0, NO_RES},
      '{cau_pkg::CMD_DIV, S_MIN, S_MAX, S_MIN, S_MIN, 1'b0, NO_RES},
      '{cau_pkg::CMD_SMUL, S_MIN, S_MAX, S_MIN, 32'sd0, 1'b0, NO_RES},
      '{cau_pkg::CMD_SDIV, ONE, ONE, 32'sd0, ONE, 1'b1,
        '{32'sd0, 32'sd0, 1'b0, 1'b1, 1'b0}},
      '{cau_pkg::CMD_SDIV, S_MIN, S_MAX, -ONE, 32'sd0, 1'b0, NO_RES},
      '{cau_pkg::CMD_CONJ, 32'sd5, S_MIN, 32'sd0, 32'sd0, 1'b1,
        '{32'sd5, S_MAX, 1'b0, 1'b0, 1'b1}},
      '{cau_pkg::CMD_MOD, 3*ONE, 4*ONE, 32'sd0, 32'sd0, 1'b1,
        '{5*ONE, 32'sd0, 1'b0, 1'b0, 1'b0}},
      '{cau_pkg::CMD_MOD, S_MIN, S_MIN, 32'sd0, 32'sd0, 1'b0, NO_RES},
      '{cau_pkg::CMD_EQUAL, S_MIN, S_MAX, S_MIN, S_MAX, 1'b1,
        '{32'sd0, 32'sd0, 1'b1, 1'b0, 1'b0}},
      '{cau_pkg::CMD_EQUAL, S_MIN, S_MAX, S_MIN, S_MIN, 1'b1, NO_RES},
      '{4'd15, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b1, NO_RES}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   cau_req_if req_if ();
   cau_rsp_if rsp_if ();

   complex_arithmetic_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   result_type pending_results [$];
   int         n_errors = 0;
   int         cycles   = 0;
   bit         quiet    = 1'b0;

   // ---------------------------------------------------------------
   // predictor: exact sign-magnitude math, truncate toward zero,
   // then saturate each part to 32 bits
   // ---------------------------------------------------------------
   function automatic logic [127:0] mag_of(input logic signed [66:0] v);
      logic signed [66:0] t;
      t = (v < 0) ? -v : v;
      return {61'd0, t};
   endfunction

   function automatic logic signed [31:0] clamp(input bit neg, input logic [127:0] mag,
                                               inout bit ovf);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (mag > lim) begin
         mag = lim;
         ovf = 1'b1;
      end
      return neg ? -mag[31:0] : mag[31:0];
   endfunction

   function automatic logic [127:0] isqrt(input logic [127:0] n);
      logic [127:0] root;
      logic [127:0] cand;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         cand = root | (128'd1 << i);
         if (cand * cand <= n) root = cand;
      end
      return root;
   endfunction

   function automatic result_type predict_result(input logic [3:0] cmd,
                                                 input logic signed [31:0] ar,
                                                 input logic signed [31:0] ai,
                                                 input logic signed [31:0] br,
                                                 input logic signed [31:0] bi);
      logic signed [66:0] sre, sim, sd;
      logic [127:0]       mre, mim;
      bit                 nre, nim, ovf;
      result_type         r;
      r = NO_RES;
      ovf = 1'b0;
      sre = '0;
      sim = '0;
      mre = '0;
      mim = '0;
      nre = 1'b0;
      nim = 1'b0;
      case (cmd)
         cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_CONJ: begin
            if (cmd == cau_pkg::CMD_ADD) begin
               sre = ar + br;
               sim = ai + bi;
            end else if (cmd == cau_pkg::CMD_SUB) begin
               sre = ar - br;
               sim = ai - bi;
            end else begin
               sre = ar;
               sim = -ai;
            end
            nre = sre < 0;  mre = mag_of(sre);
            nim = sim < 0;  mim = mag_of(sim);
         end
         cau_pkg::CMD_MUL, cau_pkg::CMD_SMUL: begin
            if (cmd == cau_pkg::CMD_MUL) begin
               sre = ar * br - ai * bi;
               sim = ar * bi + ai * br;
            end else begin
               sre = ar * br;
               sim = ai * br;
            end
            nre = sre < 0;  mre = mag_of(sre) >> 16;
            nim = sim < 0;  mim = mag_of(sim) >> 16;
         end
         cau_pkg::CMD_DIV: begin
            sd = br * br + bi * bi;
            if (sd == 0) begin
               r.div_zero = 1'b1;
               return r;
            end
            sre = ar * br + ai * bi;
            sim = ai * br - ar * bi;
            nre = sre < 0;  mre = (mag_of(sre) << 16) / mag_of(sd);
            nim = sim < 0;  mim = (mag_of(sim) << 16) / mag_of(sd);
         end
         cau_pkg::CMD_SDIV: begin
            if (br == 0) begin
               r.div_zero = 1'b1;
               return r;
            end
            nre = ar[31] ^ br[31];  mre = (mag_of(ar) << 16) / mag_of(br);
            nim = ai[31] ^ br[31];  mim = (mag_of(ai) << 16) / mag_of(br);
         end
         cau_pkg::CMD_MOD: begin
            sd = ar * ar + ai * ai;
            mre = isqrt(mag_of(sd));
         end
         cau_pkg::CMD_EQUAL: begin
            r.is_equal = (ar == br) && (ai == bi);
            return r;
         end
         default: return r;    // unknown command: all zero
      endcase
      r.res_re = clamp(nre, mre, ovf);
      r.res_im = clamp(nim, mim, ovf);
      r.overflow = ovf;
      return r;
   endfunction

   // operand mix: extremes and zeros often enough to hit every corner
   function automatic logic signed [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return $signed($urandom_range(0, 1 << 18)) - 32'sd131072;
         1: begin
            case ($urandom_range(0, 5))
               0: return S_MAX;
               1: return S_MIN;
               2: return -32'sd1;
               3: return ONE;
               4: return -ONE;
               default: return 32'sd1;
            endcase
         end
         2: return 32'sd0;
         3: return $signed($urandom_range(0, 1 << 24)) - 32'sd8388608;
         default: return $signed($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------
   // word driver: one word at a time, held until accepted
   // ---------------------------------------------------------------
   task automatic send_word(input stim_row_type row);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= row.command;
      req_if.a_re    <= row.a_re;
      req_if.a_im    <= row.a_im;
      req_if.b_re    <= row.b_re;
      req_if.b_im    <= row.b_im;
      do @(posedge clock); while (!req_if.ready);
      // accepted at this edge
      if (row.typed) pending_results.push_back(row.res);
      else pending_results.push_back(predict_result(row.command, row.a_re, row.a_im,
                                                    row.b_re, row.b_im));
   endtask

   // ---------------------------------------------------------------
   // result side: random stalls in bursts, none near the end
   // ---------------------------------------------------------------
   initial begin
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   // compare each word against the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word re=%h im=%h", $time, rsp_if.res_re, rsp_if.res_im);
            n_errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.res_re !== want.res_re) begin
               $display("%0t: res_re expected %h actual %h", $time, want.res_re, rsp_if.res_re);
               n_errors++;
            end
            if (rsp_if.res_im !== want.res_im) begin
               $display("%0t: res_im expected %h actual %h", $time, want.res_im, rsp_if.res_im);
               n_errors++;
            end
            if (rsp_if.is_equal !== want.is_equal) begin
               $display("%0t: is_equal expected %b actual %b", $time, want.is_equal,
                        rsp_if.is_equal);
               n_errors++;
            end
            if (rsp_if.div_zero !== want.div_zero) begin
               $display("%0t: div_zero expected %b actual %b", $time, want.div_zero,
                        rsp_if.div_zero);
               n_errors++;
            end
            if (rsp_if.overflow !== want.overflow) begin
               $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                        rsp_if.overflow);
               n_errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      stim_row_type row;
      req_if.valid   <= 1'b0;
      req_if.command <= '0;
      req_if.a_re    <= '0;
      req_if.a_im    <= '0;
      req_if.b_re    <= '0;
      req_if.b_im    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIR; i++) send_word(dir_tab[i]);

      for (int i = 0; i < RAND_WORDS; i++) begin
         if (i >= RAND_WORDS - QUIET_TAIL) quiet = 1'b1;
         row = '0;
         if ($urandom_range(0, 19) < 18) row.command = 4'($urandom_range(0, 8));
         else row.command = 4'($urandom_range(9, 15));
         row.a_re = pick_operand();
         row.a_im = pick_operand();
         row.b_re = pick_operand();
         row.b_im = pick_operand();
         // equality needs matching operands now and then
         if (row.command == cau_pkg::CMD_EQUAL && $urandom_range(0, 1) == 1) begin
            row.b_re = row.a_re;
            if ($urandom_range(0, 3) != 0) row.b_im = row.a_im;
         end
         send_word(row);
      end
      req_if.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (n_errors == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== complex_arithmetic_unit.f =====
src/cau_pkg.sv
src/cau_req_if.sv
src/cau_rsp_if.sv
src/cau_front.sv
src/cau_queue.sv
src/cau_back.sv
src/complex_arithmetic_unit.sv
verif/tb_top.sv
